/* design/gqg_pkg.sv */
// shared types and constants of the glyph quad generator
package gqg_pkg;

    localparam int GLYPH_COUNT_DEF = 128;
    localparam int QUAD_VERTS      = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [11:0] SCALE_RESET = 12'd256;
    localparam logic [15:0] INV_W_RESET = 16'd64;
    localparam logic [15:0] INV_H_RESET = 16'd64;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCALE = 2'd0,
        CFG_INV_W = 2'd1,
        CFG_INV_H = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] scale;
        logic [15:0] inv_w;
        logic [15:0] inv_h;
    } cfg_t;

    // one classified input item as it sits in the queue
    typedef struct packed {
        kind_t              kind;
        logic               code_ok;
        logic [6:0]         code;
        logic signed [8:0]  advance_x;
        logic signed [8:0]  advance_y;
        logic signed [8:0]  bearing_left;
        logic signed [8:0]  bearing_top;
        logic [7:0]         bitmap_width;
        logic [7:0]         bitmap_height;
        logic [15:0]        atlas_u;
        logic [15:0]        atlas_v;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } item_t;

    // one job for the output sequencer: a whole quad or a count
    typedef struct packed {
        logic               is_total;
        logic signed [20:0] left;
        logic signed [20:0] right;
        logic signed [20:0] top;
        logic signed [20:0] bottom;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
        logic [15:0]        total;
    } job_t;

endpackage

/* design/glyph_quad_generator_unit.sv */
// top level of the glyph quad generator: config registers and the three parts
//
// usage
//   input channel in_valid/in_ready carries one item per handshake: a glyph
//   table load, a string start, a character or a string end
//   output channel out_valid/out_ready carries vertices (is_total low) or the
//   string's saturating vertex count (is_total high)
//   cfg_we/cfg_index/cfg_data write glyph_scale, inv_atlas_width and
//   inv_atlas_height; write them only while the block is idle
// timing
//   an item sits in a two-entry queue, then passes a table read stage and a
//   multiply stage; the first vertex of a character or the count of an end
//   item is registered in the output sequencer and shows on the output from there
//   loads, starts and invisible characters retire one per cycle unless the
//   pipeline is stalled; a visible character holds the output sequencer for
//   its six vertices, so characters stream at the pace of the single result channel
// reset
//   glyph table reads as zero, pen and count clear, scale 1.0, reciprocals 64
// stalls
//   when out_ready is low the sequencer holds its job, the pipeline freezes
//   behind it and the queue fills, after which in_ready drops
module glyph_quad_generator_unit #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gqg_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [gqg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             kind,
    input  logic [6:0]                             char_code,
    input  logic signed [8:0]                      advance_x,
    input  logic signed [8:0]                      advance_y,
    input  logic signed [8:0]                      bearing_left,
    input  logic signed [8:0]                      bearing_top,
    input  logic [7:0]                             bitmap_width,
    input  logic [7:0]                             bitmap_height,
    input  logic [15:0]                            atlas_u,
    input  logic [15:0]                            atlas_v,
    input  logic signed [15:0]                     start_x,
    input  logic signed [15:0]                     start_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   is_total,
    output logic signed [20:0]                     vertex_x,
    output logic signed [20:0]                     vertex_y,
    output logic [16:0]                            vertex_u,
    output logic [16:0]                            vertex_v,
    output logic                                   last_vertex,
    output logic [15:0]                            vertex_total
);
    import gqg_pkg::*;

    cfg_t  cfg_reg;
    item_t head;
    logic  head_valid;
    logic  pop;
    job_t  job;
    logic  job_valid;
    logic  emit_free;

    // config registers, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale <= SCALE_RESET;
            cfg_reg.inv_w <= INV_W_RESET;
            cfg_reg.inv_h <= INV_H_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE: cfg_reg.scale <= cfg_data[11:0];
                CFG_INV_W: cfg_reg.inv_w <= cfg_data;
                CFG_INV_H: cfg_reg.inv_h <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: accept, classify and queue
    gqg_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .char_code     (char_code),
        .advance_x     (advance_x),
        .advance_y     (advance_y),
        .bearing_left  (bearing_left),
        .bearing_top   (bearing_top),
        .bitmap_width  (bitmap_width),
        .bitmap_height (bitmap_height),
        .atlas_u       (atlas_u),
        .atlas_v       (atlas_v),
        .start_x       (start_x),
        .start_y       (start_y),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop)
    );

    // back: glyph table, products, pen and count
    gqg_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .job        (job),
        .job_valid  (job_valid),
        .emit_free  (emit_free)
    );

    // output sequencer
    gqg_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_valid    (job_valid),
        .emit_free    (emit_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_total     (is_total),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_u     (vertex_u),
        .vertex_v     (vertex_v),
        .last_vertex  (last_vertex),
        .vertex_total (vertex_total)
    );

endmodule

/* design/gqg_front.sv */
// input side: takes items, classifies them and queues them for the back end
module gqg_front #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [6:0]          char_code,
    input  logic signed [8:0]   advance_x,
    input  logic signed [8:0]   advance_y,
    input  logic signed [8:0]   bearing_left,
    input  logic signed [8:0]   bearing_top,
    input  logic [7:0]          bitmap_width,
    input  logic [7:0]          bitmap_height,
    input  logic [15:0]         atlas_u,
    input  logic [15:0]         atlas_v,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    output gqg_pkg::item_t      head,
    output logic                head_valid,
    input  logic                pop
);
    import gqg_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t          queue_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           push;
    item_t          item;

    // classify the incoming item
    always_comb
    begin
        item.kind          = kind_t'(kind);
        item.code_ok       = ({25'b0, char_code} < GLYPH_COUNT);
        item.code          = char_code;
        item.advance_x     = advance_x;
        item.advance_y     = advance_y;
        item.bearing_left  = bearing_left;
        item.bearing_top   = bearing_top;
        item.bitmap_width  = bitmap_width;
        item.bitmap_height = bitmap_height;
        item.atlas_u       = atlas_u;
        item.atlas_v       = atlas_v;
        item.start_x       = start_x;
        item.start_y       = start_y;
    end

    assign in_ready   = (count_reg != (QAW+1)'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* design/gqg_back.sv */
// execution side: glyph table, scaling multipliers, pen and vertex count
module gqg_back #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gqg_pkg::cfg_t  cfg,
    input  gqg_pkg::item_t head,
    input  logic           head_valid,
    output logic           pop,
    output gqg_pkg::job_t  job,
    output logic           job_valid,
    input  logic           emit_free
);
    import gqg_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT);

    typedef struct packed {
        logic signed [8:0] adv_x;
        logic signed [8:0] adv_y;
        logic signed [8:0] bear_l;
        logic signed [8:0] bear_t;
        logic [7:0]        bw;
        logic [7:0]        bh;
        logic [15:0]       u;
        logic [15:0]       v;
    } glyph_t;

    function automatic logic signed [20:0] sat_xy(input logic signed [25:0] v);
        if (v > 26'sd1048575)
        begin
            return 21'sh0FFFFF;
        end
        else if (v < -26'sd1048576)
        begin
            return 21'sh100000;
        end
        return v[20:0];
    endfunction

    function automatic logic [16:0] sat_uv(input logic [24:0] v);
        return (v > 25'd131071) ? 17'h1FFFF : v[16:0];
    endfunction

    // truncate a Q.8 pen toward zero and clamp to 16-bit signed
    function automatic logic signed [15:0] pen_trunc(input logic signed [24:0] v);
        logic signed [24:0] b;
        logic signed [16:0] t;
        b = v + (v[24] ? 25'sd255 : 25'sd0);
        t = b[24:8];
        if (t > 17'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (t < -17'sd32768)
        begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // glyph table
    glyph_t             glyph_mem [GLYPH_COUNT];
    glyph_t             rd_reg;
    logic [GLYPH_COUNT-1:0] loaded_reg;
    logic [AW-1:0]      addr;
    glyph_t             wr_entry;
    logic               load_we;
    logic               advance;

    // stage one: table read
    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic               s1_hit_reg;
    logic signed [15:0] s1_start_x_reg;
    logic signed [15:0] s1_start_y_reg;
    glyph_t             g;

    // stage two: products
    logic               s2_valid_reg;
    kind_t              s2_kind_reg;
    logic signed [15:0] s2_start_x_reg;
    logic signed [15:0] s2_start_y_reg;
    logic signed [20:0] s2_bl_s_reg;
    logic signed [20:0] s2_bt_s_reg;
    logic signed [20:0] s2_ax_s_reg;
    logic signed [20:0] s2_ay_s_reg;
    logic [19:0]        s2_w_reg;
    logic [19:0]        s2_h_reg;
    logic [23:0]        s2_uw_reg;
    logic [23:0]        s2_vh_reg;
    logic [15:0]        s2_u0_reg;
    logic [15:0]        s2_v0_reg;

    logic signed [20:0] bl_s;
    logic signed [20:0] bt_s;
    logic signed [20:0] ax_s;
    logic signed [20:0] ay_s;
    logic [19:0]        w;
    logic [19:0]        h;
    logic [23:0]        uw;
    logic [23:0]        vh;

    // retire: pen and count
    logic signed [15:0] pen_x_reg;
    logic signed [15:0] pen_y_reg;
    logic [15:0]        count_reg;
    logic [15:0]        count_next;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [25:0] left;
    logic signed [25:0] right;
    logic signed [25:0] top;
    logic signed [25:0] bottom;
    logic signed [24:0] adv_x_sum;
    logic signed [24:0] adv_y_sum;
    logic [24:0]        u1_sum;
    logic [24:0]        v1_sum;
    logic               has_quad;
    logic               needs_emit;
    logic               retire;

    assign addr    = AW'(head.code);
    assign pop     = head_valid && advance;
    assign load_we = pop && (head.kind == KIND_LOAD) && head.code_ok;

    always_comb
    begin
        wr_entry.adv_x  = head.advance_x;
        wr_entry.adv_y  = head.advance_y;
        wr_entry.bear_l = head.bearing_left;
        wr_entry.bear_t = head.bearing_top;
        wr_entry.bw     = head.bitmap_width;
        wr_entry.bh     = head.bitmap_height;
        wr_entry.u      = head.atlas_u;
        wr_entry.v      = head.atlas_v;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            glyph_mem[addr] <= wr_entry;
        end
        if (pop)
        begin
            rd_reg <= glyph_mem[addr];
        end
    end

    // entries never loaded read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (load_we)
        begin
            loaded_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pop && (head.kind != KIND_LOAD);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg    <= head.kind;
            s1_hit_reg     <= head.code_ok && loaded_reg[addr];
            s1_start_x_reg <= head.start_x;
            s1_start_y_reg <= head.start_y;
        end
    end

    assign g = s1_hit_reg ? rd_reg : '0;

    assign bl_s = 21'(g.bear_l) * 21'($signed({1'b0, cfg.scale}));
    assign bt_s = 21'(g.bear_t) * 21'($signed({1'b0, cfg.scale}));
    assign ax_s = 21'(g.adv_x) * 21'($signed({1'b0, cfg.scale}));
    assign ay_s = 21'(g.adv_y) * 21'($signed({1'b0, cfg.scale}));
    assign w    = 20'(g.bw) * 20'(cfg.scale);
    assign h    = 20'(g.bh) * 20'(cfg.scale);
    assign uw   = 24'(g.bw) * 24'(cfg.inv_w);
    assign vh   = 24'(g.bh) * 24'(cfg.inv_h);

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_kind_reg    <= s1_kind_reg;
            s2_start_x_reg <= s1_start_x_reg;
            s2_start_y_reg <= s1_start_y_reg;
            s2_bl_s_reg    <= bl_s;
            s2_bt_s_reg    <= bt_s;
            s2_ax_s_reg    <= ax_s;
            s2_ay_s_reg    <= ay_s;
            s2_w_reg       <= w;
            s2_h_reg       <= h;
            s2_uw_reg      <= uw;
            s2_vh_reg      <= vh;
            s2_u0_reg      <= g.u;
            s2_v0_reg      <= g.v;
        end
    end

    // corners and new pen from the current pen
    assign px        = {pen_x_reg, 8'h00};
    assign py        = {pen_y_reg, 8'h00};
    assign left      = 26'(px) + 26'(s2_bl_s_reg);
    assign right     = 26'(px) + 26'(s2_bl_s_reg) + 26'($signed({1'b0, s2_w_reg}));
    assign top       = 26'(py) + 26'(s2_bt_s_reg);
    assign bottom    = 26'(py) + 26'(s2_bt_s_reg) - 26'($signed({1'b0, s2_h_reg}));
    assign adv_x_sum = 25'(px) + 25'(s2_ax_s_reg);
    assign adv_y_sum = 25'(py) + 25'(s2_ay_s_reg);
    assign u1_sum    = 25'(s2_u0_reg) + 25'(s2_uw_reg);
    assign v1_sum    = 25'(s2_v0_reg) + 25'(s2_vh_reg);
    assign has_quad  = (s2_w_reg != '0) && (s2_h_reg != '0);

    assign needs_emit = s2_valid_reg
                        && (((s2_kind_reg == KIND_CHAR) && has_quad) || (s2_kind_reg == KIND_END));
    assign advance    = !(needs_emit && !emit_free);
    assign retire     = s2_valid_reg && advance;
    assign job_valid  = needs_emit && emit_free;

    always_comb
    begin
        job.is_total = (s2_kind_reg == KIND_END);
        job.left     = sat_xy(left);
        job.right    = sat_xy(right);
        job.top      = sat_xy(top);
        job.bottom   = sat_xy(bottom);
        job.u0       = {1'b0, s2_u0_reg};
        job.u1       = sat_uv(u1_sum);
        job.v0       = {1'b0, s2_v0_reg};
        job.v1       = sat_uv(v1_sum);
        job.total    = count_reg;
    end

    assign count_next = (count_reg > 16'(16'hFFFF - QUAD_VERTS)) ? 16'hFFFF
                        : count_reg + 16'(QUAD_VERTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            count_reg <= '0;
        end
        else if (retire)
        begin
            unique case (s2_kind_reg)
                KIND_START:
                begin
                    pen_x_reg <= s2_start_x_reg;
                    pen_y_reg <= s2_start_y_reg;
                    count_reg <= '0;
                end
                KIND_CHAR:
                begin
                    pen_x_reg <= pen_trunc(adv_x_sum);
                    pen_y_reg <= pen_trunc(adv_y_sum);
                    if (has_quad)
                    begin
                        count_reg <= count_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* design/gqg_emit.sv */
// output sequencer: holds one job and plays it out as six vertices or one count
module gqg_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  gqg_pkg::job_t      job,
    input  logic               job_valid,
    output logic               emit_free,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_total,
    output logic signed [20:0] vertex_x,
    output logic signed [20:0] vertex_y,
    output logic [16:0]        vertex_u,
    output logic [16:0]        vertex_v,
    output logic               last_vertex,
    output logic [15:0]        vertex_total
);
    import gqg_pkg::*;

    localparam int BW = $clog2(QUAD_VERTS);
    localparam logic [BW-1:0] LAST_BEAT = BW'(QUAD_VERTS - 1);

    job_t          job_reg;
    logic          valid_reg;
    logic [BW-1:0] beat_reg;
    logic          last_beat;
    logic          use_right;
    logic          use_bottom;

    // triangle order: lt, rt, lb, rt, lb, rb
    assign use_right  = beat_reg[0];
    assign use_bottom = (beat_reg == BW'(2)) || (beat_reg == BW'(4)) || (beat_reg == LAST_BEAT);
    assign last_beat  = job_reg.is_total || (beat_reg == LAST_BEAT);
    assign emit_free  = !valid_reg || (out_ready && last_beat);

    assign out_valid    = valid_reg;
    assign is_total     = job_reg.is_total;
    assign vertex_x     = job_reg.is_total ? '0 : (use_right ? job_reg.right : job_reg.left);
    assign vertex_y     = job_reg.is_total ? '0 : (use_bottom ? job_reg.bottom : job_reg.top);
    assign vertex_u     = job_reg.is_total ? '0 : (use_right ? job_reg.u1 : job_reg.u0);
    assign vertex_v     = job_reg.is_total ? '0 : (use_bottom ? job_reg.v1 : job_reg.v0);
    assign last_vertex  = !job_reg.is_total && (beat_reg == LAST_BEAT);
    assign vertex_total = job_reg.is_total ? job_reg.total : '0;

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else if (job_valid)
        begin
            valid_reg <= 1'b1;
            beat_reg  <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_beat)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 1'b1;
            end
        end
    end

endmodule
